[rtl/ipfac_pkg.sv]
`default_nettype none

package ipfac_pkg;

    typedef enum logic [1:0] {
        ACT_FRAME  = 2'd0,
        ACT_IGNORE = 2'd1,
        ACT_KEEP   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        VERDICT_NON_IP  = 2'd0,
        VERDICT_LOCAL   = 2'd1,
        VERDICT_IGNORED = 2'd2,
        VERDICT_COUNTED = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        CLASS_UDP   = 2'd0,
        CLASS_TCP   = 2'd1,
        CLASS_ICMP  = 2'd2,
        CLASS_OTHER = 2'd3
    } proto_class_t;

    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;

    localparam int          HDR_SLOTS  = 24;
    localparam int          SLOT_W     = $clog2(HDR_SLOTS);
    localparam logic [5:0]  HDR_FIRST  = 6'd12;
    localparam logic [5:0]  HDR_END    = 6'd36;
    localparam logic [5:0]  POS_MAX    = 6'd63;
    localparam logic [5:0]  MIN_TYPE14 = 6'd14;
    localparam logic [5:0]  MIN_TYPE16 = 6'd16;
    localparam logic [5:0]  MIN_IP14   = 6'd34;
    localparam logic [5:0]  MIN_IP16   = 6'd36;

    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one queued job: a finished frame or a table write
    typedef struct packed {
        action_t     kind;
        logic        flag;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [15:0] len;
        logic [7:0]  proto;
        logic [2:0]  idx;
    } job_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

[rtl/ip_frame_accounting_classifier_unit.sv]
// path: a result enters the job queue when its last byte beat is taken and is
//   registered onto m_axis when it leaves the queue, after the jobs ahead of it
// throughput: one beat per cycle; last-byte and table-write beats pass a 4-entry
//   job queue, and s_axis_tready drops only while that queue is full
// table writes and verdicts exit in arrival order, one per cycle if m_axis is free
// reset: tables invalid, local mask all ones, byte position zero, queue empty
`default_nettype none

module ip_frame_accounting_classifier_unit #(
    parameter int NET_ENTRIES = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // frame_byte, entry_index, entry_network, entry_netmask, entry_valid, zero pad
    input  wire [79:0]  s_axis_tdata,
    // action
    input  wire [1:0]   s_axis_tuser,
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // verdict, proto_class, source_address, dest_address, ip_length, zero pad
    output logic [87:0] m_axis_tdata,
    input  wire         cfg_wr_en,
    input  wire [31:0]  cfg_wr_data
);
    import ipfac_pkg::*;

    logic         acc;
    logic         push;
    logic         pop;
    job_t         push_job;
    job_t         pop_job;
    q_status_t    q_status;
    verdict_t     verdict;
    proto_class_t proto_class;
    logic [31:0]  source_address;
    logic [31:0]  dest_address;
    logic [15:0]  ip_length;

    assign s_axis_tready = !q_status.full;
    assign acc           = s_axis_tvalid && s_axis_tready;

    ipfac_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .acc           (acc),
        .action        (action_t'(s_axis_tuser)),
        .frame_byte    (s_axis_tdata[7:0]),
        .frame_last    (s_axis_tlast),
        .entry_index   (s_axis_tdata[10:8]),
        .entry_network (s_axis_tdata[42:11]),
        .entry_netmask (s_axis_tdata[74:43]),
        .entry_valid   (s_axis_tdata[75]),
        .push          (push),
        .job           (push_job)
    );

    ipfac_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    ipfac_back #(
        .NET_ENTRIES (NET_ENTRIES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_status       (q_status),
        .job            (pop_job),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .verdict        (verdict),
        .proto_class    (proto_class),
        .source_address (source_address),
        .dest_address   (dest_address),
        .ip_length      (ip_length)
    );

    assign m_axis_tdata = {4'b0000, ip_length, dest_address, source_address,
                           proto_class, verdict};

endmodule

`default_nettype wire

[rtl/ipfac_front.sv]
`default_nettype none

module ipfac_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 acc,
    input  wire ipfac_pkg::action_t action,
    input  wire [7:0]           frame_byte,
    input  wire                 frame_last,
    input  wire [2:0]           entry_index,
    input  wire [31:0]          entry_network,
    input  wire [31:0]          entry_netmask,
    input  wire                 entry_valid,
    output logic                push,
    output ipfac_pkg::job_t     job
);
    import ipfac_pkg::*;

    // header slot offsets relative to byte 12, for an ip header at byte 14
    localparam int OFS_LEN   = 4;
    localparam int OFS_PROTO = 11;
    localparam int OFS_SRC   = 14;
    localparam int OFS_DST   = 18;
    localparam int SHIFT16   = 2;

    logic [5:0]        pos_reg;
    logic [5:0]        pos_next;
    logic [7:0]        hdr_reg [HDR_SLOTS];
    logic [7:0]        hdr_cur [HDR_SLOTS];
    logic [5:0]        n_bytes;
    logic [5:0]        slot_full;
    logic [SLOT_W-1:0] slot;
    logic              in_hdr;
    logic              frame_beat;
    logic              type14;
    logic              type16;
    logic              base14;
    logic              base16;
    logic              ip_ok;
    logic [31:0]       src14;
    logic [31:0]       src16;
    logic [31:0]       dst14;
    logic [31:0]       dst16;

    assign frame_beat = acc && (action == ACT_FRAME);
    assign in_hdr     = (pos_reg >= HDR_FIRST) && (pos_reg < HDR_END);
    assign slot_full  = pos_reg - HDR_FIRST;
    assign slot       = slot_full[SLOT_W-1:0];
    assign n_bytes    = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 6'd1;

    always_comb
    begin
        hdr_cur = hdr_reg;
        if (in_hdr)
        begin
            hdr_cur[slot] = frame_byte;
        end
    end

    // type field at bytes 12-13, else 14-15
    assign type14 = (n_bytes >= MIN_TYPE14) && ({hdr_cur[0], hdr_cur[1]} == TYPE_IPV4);
    assign type16 = (n_bytes >= MIN_TYPE16) && ({hdr_cur[2], hdr_cur[3]} == TYPE_IPV4);
    assign base14 = type14;
    assign base16 = !type14 && type16;
    assign ip_ok  = (base14 && (n_bytes >= MIN_IP14)) || (base16 && (n_bytes >= MIN_IP16));

    assign src14 = {hdr_cur[OFS_SRC], hdr_cur[OFS_SRC+1], hdr_cur[OFS_SRC+2],
                    hdr_cur[OFS_SRC+3]};
    assign src16 = {hdr_cur[OFS_SRC+SHIFT16], hdr_cur[OFS_SRC+SHIFT16+1],
                    hdr_cur[OFS_SRC+SHIFT16+2], hdr_cur[OFS_SRC+SHIFT16+3]};
    assign dst14 = {hdr_cur[OFS_DST], hdr_cur[OFS_DST+1], hdr_cur[OFS_DST+2],
                    hdr_cur[OFS_DST+3]};
    assign dst16 = {hdr_cur[OFS_DST+SHIFT16], hdr_cur[OFS_DST+SHIFT16+1],
                    hdr_cur[OFS_DST+SHIFT16+2], hdr_cur[OFS_DST+SHIFT16+3]};

    always_comb
    begin
        job = '0;
        push = 1'b0;
        case (action)
            ACT_FRAME:
            begin
                push       = acc && frame_last;
                job.kind   = ACT_FRAME;
                job.flag   = ip_ok;
                if (ip_ok)
                begin
                    job.word_a = base16 ? src16 : src14;
                    job.word_b = base16 ? dst16 : dst14;
                    job.len    = base16 ? {hdr_cur[OFS_LEN+SHIFT16], hdr_cur[OFS_LEN+SHIFT16+1]}
                                        : {hdr_cur[OFS_LEN], hdr_cur[OFS_LEN+1]};
                    job.proto  = base16 ? hdr_cur[OFS_PROTO+SHIFT16] : hdr_cur[OFS_PROTO];
                end
            end
            ACT_IGNORE, ACT_KEEP:
            begin
                push       = acc;
                job.kind   = action;
                job.flag   = entry_valid;
                job.word_a = entry_network;
                job.word_b = entry_netmask;
                job.idx    = entry_index;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (frame_beat)
        begin
            pos_next = frame_last ? 6'd0 : n_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 6'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_beat)
        begin
            hdr_reg <= hdr_cur;
        end
    end

    a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_beat && frame_last) |=> (pos_reg == 6'd0))
        else $error("byte position not cleared after last beat");

endmodule

`default_nettype wire

[rtl/ipfac_queue.sv]
`default_nettype none

module ipfac_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  wire ipfac_pkg::job_t  push_job,
    input  wire                   pop,
    output ipfac_pkg::job_t       pop_job,
    output ipfac_pkg::q_status_t  status
);
    import ipfac_pkg::*;

    job_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] PTR_ONE  = QPTR_W'(1);
    localparam logic [QCNT_W-1:0] CNT_ONE  = QCNT_W'(1);

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_FULL);
    assign do_pop       = pop && status.valid;
    assign pop_job      = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

`default_nettype wire

[rtl/ipfac_back.sv]
`default_nettype none

module ipfac_back #(
    parameter int NET_ENTRIES = 8
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_wr_en,
    input  wire [31:0]            cfg_wr_data,
    input  wire ipfac_pkg::q_status_t q_status,
    input  wire ipfac_pkg::job_t  job,
    output logic                  pop,
    output logic                  out_valid,
    input  wire                   out_ready,
    output ipfac_pkg::verdict_t   verdict,
    output ipfac_pkg::proto_class_t proto_class,
    output logic [31:0]           source_address,
    output logic [31:0]           dest_address,
    output logic [15:0]           ip_length
);
    import ipfac_pkg::*;

    logic [31:0]  local_mask_reg;
    logic         ign_vld_reg  [NET_ENTRIES];
    logic [31:0]  ign_net_reg  [NET_ENTRIES];
    logic [31:0]  ign_mask_reg [NET_ENTRIES];
    logic         keep_vld_reg [NET_ENTRIES];
    logic [31:0]  keep_net_reg [NET_ENTRIES];
    logic [31:0]  keep_mask_reg[NET_ENTRIES];

    logic         out_valid_reg;
    logic         out_valid_next;
    verdict_t     verdict_reg;
    verdict_t     verdict_next;
    proto_class_t class_reg;
    proto_class_t class_next;
    logic [31:0]  src_reg;
    logic [31:0]  dst_reg;
    logic [15:0]  len_reg;

    logic         is_frame;
    logic         pop_frame;
    logic         ign_hit;
    logic         keep_hit;

    assign is_frame  = (job.kind == ACT_FRAME);
    assign pop       = q_status.valid && (!is_frame || !out_valid_reg || out_ready);
    assign pop_frame = pop && is_frame;

    // parallel table match on both addresses
    always_comb
    begin
        ign_hit  = 1'b0;
        keep_hit = 1'b0;
        for (int i = 0; i < NET_ENTRIES; i++)
        begin
            if (ign_vld_reg[i] && (((job.word_a & ign_mask_reg[i]) == ign_net_reg[i]) ||
                                   ((job.word_b & ign_mask_reg[i]) == ign_net_reg[i])))
            begin
                ign_hit = 1'b1;
            end
            if (keep_vld_reg[i] && (((job.word_a & keep_mask_reg[i]) == keep_net_reg[i]) ||
                                    ((job.word_b & keep_mask_reg[i]) == keep_net_reg[i])))
            begin
                keep_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        verdict_next = VERDICT_COUNTED;
        class_next   = CLASS_UDP;
        if (!job.flag)
        begin
            verdict_next = VERDICT_NON_IP;
        end
        else if ((job.word_a & local_mask_reg) == (job.word_b & local_mask_reg))
        begin
            verdict_next = VERDICT_LOCAL;
        end
        else if (ign_hit && !keep_hit)
        begin
            verdict_next = VERDICT_IGNORED;
        end
        else
        begin
            verdict_next = VERDICT_COUNTED;
            case (job.proto)
                PROTO_UDP:  class_next = CLASS_UDP;
                PROTO_TCP:  class_next = CLASS_TCP;
                PROTO_ICMP: class_next = CLASS_ICMP;
                default:    class_next = CLASS_OTHER;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop_frame)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            local_mask_reg <= 32'hFFFF_FFFF;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                local_mask_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_frame)
        begin
            verdict_reg <= verdict_next;
            class_reg   <= class_next;
            src_reg     <= job.word_a;
            dst_reg     <= job.word_b;
            len_reg     <= job.len;
        end
    end

    // slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NET_ENTRIES; i++)
            begin
                ign_vld_reg[i]  <= 1'b0;
                keep_vld_reg[i] <= 1'b0;
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < NET_ENTRIES; i++)
            begin
                if (int'(job.idx) == i)
                begin
                    if (job.kind == ACT_IGNORE)
                    begin
                        ign_vld_reg[i] <= job.flag;
                    end
                    if (job.kind == ACT_KEEP)
                    begin
                        keep_vld_reg[i] <= job.flag;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < NET_ENTRIES; i++)
            begin
                if (int'(job.idx) == i)
                begin
                    if (job.kind == ACT_IGNORE)
                    begin
                        ign_net_reg[i]  <= job.word_a;
                        ign_mask_reg[i] <= job.word_b;
                    end
                    if (job.kind == ACT_KEEP)
                    begin
                        keep_net_reg[i]  <= job.word_a;
                        keep_mask_reg[i] <= job.word_b;
                    end
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign proto_class    = class_reg;
    assign source_address = src_reg;
    assign dest_address   = dst_reg;
    assign ip_length      = len_reg;

    a_class_only_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (verdict_reg != VERDICT_COUNTED)) |-> (class_reg == CLASS_UDP))
        else $error("protocol class set on uncounted frame");

    a_non_ip_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (verdict_reg == VERDICT_NON_IP)) |->
        ((src_reg == 32'd0) && (dst_reg == 32'd0) && (len_reg == 16'd0)))
        else $error("non-ip result carries header fields");

endmodule

`default_nettype wire
